// ===== hw/rtl/rgbhsv_pkg.sv =====
// Shared types and constants for the RGB to HSV pixel converter.
// No dependencies; imported by every module of the block.
package rgbhsv_pkg;

  // Field widths
  localparam int CHANNEL_BITS  = 8;
  localparam int FRACTION_BITS = 16;
  // Hue divisor is six times the spread: three extra bits
  localparam int HUE_DEN_BITS  = CHANNEL_BITS + 3;
  // One quotient bit is resolved per divider stage
  localparam int DIV_STAGES    = FRACTION_BITS;

  typedef logic [CHANNEL_BITS-1:0]  chan_t;
  typedef logic [FRACTION_BITS-1:0] frac_t;
  typedef logic [HUE_DEN_BITS-1:0]  hue_den_t;

  // Input request payload
  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

  // Result request payload
  typedef struct packed {
    frac_t hue_fraction;
    frac_t saturation_fraction;
    chan_t brightness;
  } hsv_t;

  // Word carried through the divider stages: two restoring divisions side by side
  typedef struct packed {
    hue_den_t hue_rem;
    hue_den_t hue_den;
    frac_t    hue_quo;
    chan_t    sat_rem;
    chan_t    sat_den;
    frac_t    sat_quo;
    logic     sat_full;
    chan_t    brightness;
  } div_word_t;

endpackage

// ===== hw/rtl/rgbhsv_front.sv =====
// Front end of the converter: max/min search, then hue numerator and divisor setup.
// Two register stages; depends on rgbhsv_pkg.
module rgbhsv_front
  import rgbhsv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      in_valid,
  input  pixel_t    in_pixel,
  output logic      out_valid,
  output div_word_t out_word
);

  // Stage A: largest and smallest channel
  logic   valid_a_r;
  pixel_t pix_a_r;
  chan_t  mx_a_r, mn_a_r;
  chan_t  mx_a_nxt, mn_a_nxt;

  always_comb begin
    mx_a_nxt = in_pixel.red;
    mn_a_nxt = in_pixel.red;
    if (in_pixel.green > mx_a_nxt) mx_a_nxt = in_pixel.green;
    if (in_pixel.blue  > mx_a_nxt) mx_a_nxt = in_pixel.blue;
    if (in_pixel.green < mn_a_nxt) mn_a_nxt = in_pixel.green;
    if (in_pixel.blue  < mn_a_nxt) mn_a_nxt = in_pixel.blue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else if (adv) begin
      valid_a_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix_a_r <= in_pixel;
      mx_a_r  <= mx_a_nxt;
      mn_a_r  <= mn_a_nxt;
    end
  end

  // Stage B: spread, sector numerator, special cases
  logic      valid_b_r;
  div_word_t word_b_r;
  div_word_t word_b_nxt;
  chan_t     spread;
  hue_den_t  spread_x, span, num;
  hue_den_t  diff_r, diff_g, diff_b;
  logic      flat, hue_ok;

  always_comb begin
    spread   = mx_a_r - mn_a_r;
    spread_x = HUE_DEN_BITS'(spread);
    span     = (spread_x << 2) + (spread_x << 1);
    diff_r   = HUE_DEN_BITS'(mx_a_r - pix_a_r.red);
    diff_g   = HUE_DEN_BITS'(mx_a_r - pix_a_r.green);
    diff_b   = HUE_DEN_BITS'(mx_a_r - pix_a_r.blue);
    // black or grey pixel
    flat     = (mx_a_r == mn_a_r);

    // six-sector numerator; ties on the maximum favor red, then green
    if (pix_a_r.red == mx_a_r) begin
      if (pix_a_r.green == mn_a_r) num = (spread_x << 2) + spread_x + diff_b;
      else                         num = spread_x - diff_g;
    end else if (pix_a_r.green == mx_a_r) begin
      if (pix_a_r.blue == mn_a_r)  num = spread_x + diff_r;
      else                         num = (spread_x << 1) + spread_x - diff_b;
    end else begin
      if (pix_a_r.red == mn_a_r)   num = (spread_x << 1) + spread_x + diff_g;
      else                         num = (spread_x << 2) + spread_x - diff_r;
    end

    // hue wraps to zero at a full turn or at zero
    hue_ok = !flat && (num != '0) && (num < span);

    word_b_nxt.hue_rem    = hue_ok ? num  : '0;
    word_b_nxt.hue_den    = hue_ok ? span : HUE_DEN_BITS'(1);
    word_b_nxt.hue_quo    = '0;
    word_b_nxt.sat_full   = !flat && (mn_a_r == '0);
    // flat pixels and full saturation (forced at the end) run a zero division
    if (flat || (mn_a_r == '0)) begin
      word_b_nxt.sat_rem  = '0;
      word_b_nxt.sat_den  = CHANNEL_BITS'(1);
    end else begin
      word_b_nxt.sat_rem  = spread;
      word_b_nxt.sat_den  = mx_a_r;
    end
    word_b_nxt.sat_quo    = '0;
    word_b_nxt.brightness = mx_a_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r <= 1'b0;
    end else if (adv) begin
      valid_b_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      word_b_r <= word_b_nxt;
    end
  end

  assign out_valid = valid_b_r;
  assign out_word  = word_b_r;

endmodule

// ===== hw/rtl/rgbhsv_div_stage.sv =====
// One restoring-division stage: resolves one quotient bit of hue and of saturation.
// Depends on rgbhsv_pkg for the stage word layout.
module rgbhsv_div_stage
  import rgbhsv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      in_valid,
  input  div_word_t in_word,
  output logic      out_valid,
  output div_word_t out_word
);

  logic                    valid_r;
  div_word_t               word_r;
  div_word_t               word_nxt;
  logic [HUE_DEN_BITS:0]   hue_two;
  logic [CHANNEL_BITS:0]   sat_two;
  logic                    hue_bit, sat_bit;

  // Shift remainder, compare against divisor, subtract when it fits
  always_comb begin
    word_nxt = in_word;

    hue_two = {in_word.hue_rem, 1'b0};
    hue_bit = (hue_two >= {1'b0, in_word.hue_den});
    word_nxt.hue_rem = hue_bit ? HUE_DEN_BITS'(hue_two - {1'b0, in_word.hue_den})
                               : hue_two[HUE_DEN_BITS-1:0];
    word_nxt.hue_quo = {in_word.hue_quo[FRACTION_BITS-2:0], hue_bit};

    sat_two = {in_word.sat_rem, 1'b0};
    sat_bit = (sat_two >= {1'b0, in_word.sat_den});
    word_nxt.sat_rem = sat_bit ? CHANNEL_BITS'(sat_two - {1'b0, in_word.sat_den})
                               : sat_two[CHANNEL_BITS-1:0];
    word_nxt.sat_quo = {in_word.sat_quo[FRACTION_BITS-2:0], sat_bit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

// ===== hw/rtl/rgb_to_hsv_convert_core.sv =====
// Top level of the RGB to HSV pixel converter.
// Depends on rgbhsv_pkg, rgbhsv_front and rgbhsv_div_stage.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one pixel per request
//   (red, green, blue). Output channel out_valid/out_ready/out_data carries
//   hue_fraction, saturation_fraction and brightness per request.
//   The block has no configuration and no state between pixels.
// Pipeline: two front stages (max/min, numerator setup) and one stage per
//   quotient bit of the two restoring dividers that run side by side.
// Throughput: one pixel per cycle unless a stalled result holds the pipeline;
//   the one-bit-per-stage divider takes a new request every clock otherwise.
// Reset: rst_n low (synchronous) clears every stage valid bit; the pipeline
//   comes up empty and in_ready is high.
// Stall: when out_ready is low with a result waiting, the whole pipeline
//   holds, bubbles included, and in_ready drops; with out_ready low and
//   the last stage empty the pipeline still advances and in_ready is high.
module rgb_to_hsv_convert_core
  import rgbhsv_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  pixel_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output hsv_t   out_data
);

  logic      adv;
  logic      stage_valid [0:DIV_STAGES];
  div_word_t stage_word  [0:DIV_STAGES];

  // Global advance: move unless a finished result is held back
  assign adv      = out_ready || !stage_valid[DIV_STAGES];
  assign in_ready = adv;

  rgbhsv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_pixel  (in_data),
    .out_valid (stage_valid[0]),
    .out_word  (stage_word[0])
  );

  // Divider chain, one quotient bit per stage
  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    rgbhsv_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (stage_valid[i]),
      .in_word   (stage_word[i]),
      .out_valid (stage_valid[i+1]),
      .out_word  (stage_word[i+1])
    );
  end

  // Result from the last stage; full saturation clamps to all ones
  assign out_valid                    = stage_valid[DIV_STAGES];
  assign out_data.hue_fraction        = stage_word[DIV_STAGES].hue_quo;
  assign out_data.saturation_fraction = stage_word[DIV_STAGES].sat_full ? '1
                                        : stage_word[DIV_STAGES].sat_quo;
  assign out_data.brightness          = stage_word[DIV_STAGES].brightness;

endmodule

// ===== hw/rtl/rgbhsv_checker.sv =====
// Port-level checker for rgb_to_hsv_convert_core, bound to the top level.
// Depends on rgbhsv_pkg for the payload types.
module rgbhsv_checker
  import rgbhsv_pkg::*;
(
  input logic   clk,
  input logic   rst_n,
  input logic   in_valid,
  input logic   in_ready,
  input pixel_t in_data,
  input logic   out_valid,
  input logic   out_ready,
  input hsv_t   out_data
);

  // A waiting input request keeps its valid and its pixel
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input request dropped or changed while waiting");

  // A held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Input is refused only while a result is held back
  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (out_ready || !out_valid))
    else $error("in_ready does not follow the output stall");

  // Black pixel gives zero hue and saturation
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.brightness == '0) |->
      (out_data.hue_fraction == '0) && (out_data.saturation_fraction == '0))
    else $error("black pixel with nonzero hue or saturation");

endmodule

bind rgb_to_hsv_convert_core rgbhsv_checker u_rgbhsv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
